@@ rtl/epoch_seconds_to_calendar_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ESC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define ESC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/esc_pkg.sv @@
package esc_pkg;

    // calendar constants
    localparam int unsigned SEC_PER_DAY       = 24 * 60 * 60;
    localparam int unsigned SEC_PER_HOUR      = 3600;
    localparam int unsigned SEC_PER_MIN       = 60;
    localparam int unsigned FIRST_YEAR        = 1970;
    localparam int unsigned BASE_YEAR         = 1968;
    localparam int unsigned DAYS_COMMON       = 365;
    localparam int unsigned DAYS_LEAP         = 366;
    localparam int unsigned DAYS_QUAD         = 3 * DAYS_COMMON + DAYS_LEAP;
    localparam int unsigned DAYS_BEFORE_FIRST = DAYS_LEAP + DAYS_COMMON;
    localparam int unsigned EPOCH_WEEKDAY     = 4;
    localparam int unsigned TOTAL_DAYS        = 47482;
    localparam int unsigned LAST_MONTH_IDX    = 11;

    // field widths
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned ZONE_W   = 12;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned WDAY_W   = 3;

    // one finished conversion, handed from the sequencer to the top level
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [WDAY_W-1:0]   weekday;
    } esc_result_t;

    // days in month, month counted from 0
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/esc_alu.sv @@
module esc_alu (
    input  logic [esc_pkg::EPOCH_W-1:0] a,
    input  logic [esc_pkg::EPOCH_W-1:0] b,
    output logic [esc_pkg::EPOCH_W-1:0] diff,
    output logic                        ge
);
    import esc_pkg::*;

    logic [EPOCH_W:0] wide_diff;

    // trial subtract, the borrow tells whether b fits into a
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign diff      = wide_diff[EPOCH_W-1:0];
    assign ge        = ~wide_diff[EPOCH_W];

endmodule

@@ rtl/esc_seq.sv @@
module esc_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [esc_pkg::EPOCH_W-1:0] load_value,
    output logic                        busy,
    output logic                        fin,
    output esc_pkg::esc_result_t        result
);
    import esc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVD  = 3'd1;
    localparam logic [2:0] ST_HOUR  = 3'd2;
    localparam logic [2:0] ST_MIN   = 3'd3;
    localparam logic [2:0] ST_WDAY  = 3'd4;
    localparam logic [2:0] ST_QUAD  = 3'd5;
    localparam logic [2:0] ST_YEAR  = 3'd6;
    localparam logic [2:0] ST_MONTH = 3'd7;

    localparam int unsigned DAYS_W = 16;

    logic [2:0]          state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [EPOCH_W-1:0]  work_reg, work_next;
    logic [DAYS_W-1:0]   quot_reg, quot_next;
    logic [DAYS_W-1:0]   days_reg, days_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [SECOND_W-1:0] second_reg, second_next;
    logic [WDAY_W-1:0]   wday_reg, wday_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic                leap_reg, leap_next;

    logic [EPOCH_W-1:0] operand;
    logic [EPOCH_W-1:0] diff;
    logic               ge;
    logic [EPOCH_W-1:0] rem_next;
    logic [DAYS_W-1:0]  quot_shift;
    logic               last_step;

    // divisor or length for the current step
    always_comb
    begin
        unique case (state_reg)
            ST_DIVD:  operand = 32'(SEC_PER_DAY) << cnt_reg;
            ST_HOUR:  operand = 32'(SEC_PER_HOUR) << cnt_reg;
            ST_MIN:   operand = 32'(SEC_PER_MIN) << cnt_reg;
            ST_WDAY:  operand = 32'(7) << cnt_reg;
            ST_QUAD:  operand = 32'(DAYS_QUAD) << cnt_reg;
            ST_YEAR:  operand = (cnt_reg == 4'd0) ? 32'(DAYS_LEAP) : 32'(DAYS_COMMON);
            ST_MONTH: operand = 32'(month_len(cnt_reg, leap_reg));
            default:  operand = '0;
        endcase
    end

    // the one shared subtract and compare unit
    esc_alu u_alu (
        .a    (work_reg),
        .b    (operand),
        .diff (diff),
        .ge   (ge)
    );

    assign rem_next   = ge ? diff : work_reg;
    assign quot_shift = {quot_reg[DAYS_W-2:0], ge};
    assign last_step  = (cnt_reg == 4'd0);

    // sequencer: day split, time of day, weekday, four-year blocks, years, months
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        work_next   = work_reg;
        quot_next   = quot_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        wday_next   = wday_reg;
        year_next   = year_reg;
        leap_next   = leap_reg;
        fin         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    work_next  = load_value;
                    quot_next  = '0;
                    cnt_next   = 4'd15;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                work_next = rem_next;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (last_step)
                begin
                    days_next  = quot_shift;
                    quot_next  = '0;
                    cnt_next   = 4'd4;
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                work_next = rem_next;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (last_step)
                begin
                    hour_next  = quot_shift[HOUR_W-1:0];
                    quot_next  = '0;
                    cnt_next   = 4'd5;
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                work_next = rem_next;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (last_step)
                begin
                    minute_next = quot_shift[MINUTE_W-1:0];
                    second_next = rem_next[SECOND_W-1:0];
                    work_next   = 32'(days_reg) + 32'(EPOCH_WEEKDAY);
                    quot_next   = '0;
                    cnt_next    = 4'd12;
                    state_next  = ST_WDAY;
                end
            end
            ST_WDAY:
            begin
                work_next = rem_next;
                cnt_next  = cnt_reg - 4'd1;
                if (last_step)
                begin
                    wday_next  = rem_next[WDAY_W-1:0];
                    work_next  = 32'(days_reg) + 32'(DAYS_BEFORE_FIRST);
                    quot_next  = '0;
                    cnt_next   = 4'd5;
                    state_next = ST_QUAD;
                end
            end
            ST_QUAD:
            begin
                work_next = rem_next;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (last_step)
                begin
                    year_next  = 12'(BASE_YEAR) + {4'b0000, quot_shift[5:0], 2'b00};
                    cnt_next   = 4'd0;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                // leap year first in each block of four, then common years
                if (ge)
                begin
                    work_next = diff;
                    cnt_next  = cnt_reg + 4'd1;
                end
                else
                begin
                    year_next  = year_reg + {8'h00, cnt_reg};
                    leap_next  = (cnt_reg == 4'd0);
                    cnt_next   = 4'd0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (ge && (cnt_reg != 4'(LAST_MONTH_IDX)))
                begin
                    work_next = diff;
                    cnt_next  = cnt_reg + 4'd1;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // working and partial result registers
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        quot_reg   <= quot_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        leap_reg   <= leap_next;
    end

    // finished fields, valid while fin is high
    always_comb
    begin
        result.year    = year_reg;
        result.month   = cnt_reg + 4'd1;
        result.day     = work_reg[DAY_W-1:0] + 5'd1;
        result.hour    = hour_reg;
        result.minute  = minute_reg;
        result.second  = second_reg;
        result.weekday = wday_reg;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// channel   | ports                                            | transfer
// ----------+--------------------------------------------------+---------------------------
// config    | zone_wr_en, zone_offset_minutes                  | any edge with zone_wr_en
// input     | start, busy, epoch_seconds                       | edge with start && !busy
// result    | done, cal_year .. week_day, range_error          | edge ending the done cycle
//
// one conversion runs from transfer to done; busy stays high meanwhile
// the serial subtract unit works in steps: 16 day-split steps, 11 for hour and minute,
// 13 for weekday, 6 for four-year blocks, up to 4 year and 12 month steps
// done rises at the edge where busy falls; a new start is taken at the edge ending done
// reset clears the zone offset to zero and returns the sequencer to idle
// the result receiver cannot stall; each result is shown for one cycle only
module epoch_seconds_to_calendar_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               zone_wr_en,
    input  logic signed [esc_pkg::ZONE_W-1:0]  zone_offset_minutes,
    input  logic                               start,
    input  logic [esc_pkg::EPOCH_W-1:0]        epoch_seconds,
    output logic                               busy,
    output logic                               done,
    output logic [esc_pkg::YEAR_W-1:0]         cal_year,
    output logic [esc_pkg::MONTH_W-1:0]        cal_month,
    output logic [esc_pkg::DAY_W-1:0]          cal_day,
    output logic [esc_pkg::HOUR_W-1:0]         clock_hour,
    output logic [esc_pkg::MINUTE_W-1:0]       clock_minute,
    output logic [esc_pkg::SECOND_W-1:0]       clock_second,
    output logic [esc_pkg::WDAY_W-1:0]         week_day,
    output logic                               range_error
);
    import esc_pkg::*;

    localparam int unsigned LOCAL_W = EPOCH_W + 2;
    localparam logic [EPOCH_W:0] MAX_LOCAL =
        33'(longint'(TOTAL_DAYS) * longint'(SEC_PER_DAY) - 64'sd1);

    logic signed [ZONE_W-1:0]  zone_reg;
    logic signed [LOCAL_W-1:0] offset_sec;
    logic signed [LOCAL_W-1:0] local_time;
    logic                      below;
    logic                      above;
    logic [EPOCH_W-1:0]        clamped;
    logic                      accept;
    logic                      err_reg;
    logic                      done_reg;
    logic                      seq_busy;
    logic                      seq_fin;
    esc_result_t               seq_result;
    esc_result_t               out_reg;

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
        end
        else if (zone_wr_en)
        begin
            zone_reg <= zone_offset_minutes;
        end
    end

    // local time and clamp into the supported range
    assign offset_sec = LOCAL_W'(zone_reg) * LOCAL_W'(SEC_PER_MIN);
    assign local_time = $signed({2'b00, epoch_seconds}) + offset_sec;
    assign below      = local_time[LOCAL_W-1];
    assign above      = !below && (local_time[EPOCH_W:0] > MAX_LOCAL);
    assign clamped    = below ? '0 :
                        above ? MAX_LOCAL[EPOCH_W-1:0] : local_time[EPOCH_W-1:0];

    assign accept = start && !seq_busy;

    esc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_value (clamped),
        .busy       (seq_busy),
        .fin        (seq_fin),
        .result     (seq_result)
    );

    // range flag travels beside the sequencer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= below || above;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= seq_fin;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (seq_fin)
        begin
            out_reg     <= seq_result;
            range_error <= err_reg;
        end
    end

    assign busy         = seq_busy;
    assign done         = done_reg;
    assign cal_year     = out_reg.year;
    assign cal_month    = out_reg.month;
    assign cal_day      = out_reg.day;
    assign clock_hour   = out_reg.hour;
    assign clock_minute = out_reg.minute;
    assign clock_second = out_reg.second;
    assign week_day     = out_reg.weekday;

endmodule

@@ rtl/esc_checker.sv @@
`include "epoch_seconds_to_calendar_unit_assert.svh"

module esc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic [esc_pkg::YEAR_W-1:0]         cal_year,
    input logic [esc_pkg::MONTH_W-1:0]        cal_month,
    input logic [esc_pkg::DAY_W-1:0]          cal_day,
    input logic [esc_pkg::HOUR_W-1:0]         clock_hour,
    input logic [esc_pkg::MINUTE_W-1:0]       clock_minute,
    input logic [esc_pkg::SECOND_W-1:0]       clock_second,
    input logic [esc_pkg::WDAY_W-1:0]         week_day,
    input logic                               range_error
);
    import esc_pkg::*;

    logic date_ok;
    logic clock_ok;

    // field ranges of a calendar date and a clock time
    assign date_ok  = (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_day >= 5'd1) &&
                      (week_day <= 3'd6);
    assign clock_ok = (clock_hour <= 5'd23) && (clock_minute <= 6'd59) &&
                      (clock_second <= 6'd59);

    // a taken item keeps the unit busy in the next cycle
    `ESC_ASSERT_NXT(a_start_busy, start && !busy, busy)

    // a result only shows once the sequencer is back at idle
    `ESC_ASSERT_IMP(a_done_idle, done, !busy)

    // every result field lies inside the calendar
    `ESC_ASSERT_IMP(a_fields_ok, done, date_ok && clock_ok)

    // a saturated result is one of the two range ends, both Thursdays
    `ESC_ASSERT_IMP(a_sat_ends, done && range_error, ((cal_year == 12'd1970) || (cal_year == 12'd2099)) && (week_day == 3'd4))

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);
